### hdl/clipped_alpha_blend_compositor_core_assert.svh
// assertion macros used by the checker file
`ifndef CLIPPED_ALPHA_BLEND_COMPOSITOR_CORE_ASSERT_SVH
`define CLIPPED_ALPHA_BLEND_COMPOSITOR_CORE_ASSERT_SVH

// property checked on every edge outside reset
`define CAB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define CAB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/cab_pkg.sv
`default_nettype none
package cab_pkg;

	localparam int MAX_FRAME_SIZE = 4096;
	localparam int CNT_W          = $clog2(MAX_FRAME_SIZE);
	localparam int SIZE_W         = 13;
	localparam int COORD_W        = 14;
	localparam int GA_W           = 9;
	localparam int PIX_W          = 32;
	localparam int IDX_W          = 4;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_AW        = $clog2(FIFO_DEPTH);

	localparam logic [GA_W-1:0] GA_FULL  = GA_W'(256);
	localparam logic [7:0]      BYTE_MAX = 8'hff;

	typedef enum logic [IDX_W-1:0] {
		REG_GLOBAL_ALPHA  = 4'd0,
		REG_X_OFFSET      = 4'd1,
		REG_Y_OFFSET      = 4'd2,
		REG_SOURCE_WIDTH  = 4'd3,
		REG_SOURCE_HEIGHT = 4'd4,
		REG_DEST_WIDTH    = 4'd5,
		REG_DEST_HEIGHT   = 4'd6,
		REG_BYTE_ORDER    = 4'd7
	} reg_idx_t;

	// register values already saturated to their legal ranges
	typedef struct packed {
		logic [GA_W-1:0]          global_alpha;
		logic signed [SIZE_W-1:0] x_offset;
		logic signed [SIZE_W-1:0] y_offset;
		logic [SIZE_W-1:0]        source_width;
		logic [SIZE_W-1:0]        source_height;
		logic [SIZE_W-1:0]        dst_w;
		logic [SIZE_W-1:0]        dst_h;
		logic                     byte_order;
	} cfg_t;

	// one classified pixel waiting for the blend
	typedef struct packed {
		logic [PIX_W-1:0]          src;
		logic [PIX_W-1:0]          dst;
		logic [7:0]                alpha;
		logic                      bgra;
		logic signed [COORD_W-1:0] col;
		logic signed [COORD_W-1:0] row;
		logic                      we;
		logic                      fe;
	} entry_t;

	function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		r = v;
		if (v == '0)
			r = SIZE_W'(1);
		else if (v > SIZE_W'(MAX_FRAME_SIZE))
			r = SIZE_W'(MAX_FRAME_SIZE);
		return r;
	endfunction

	// (d*(255-a) + s*a) >> 8, sum stays below 2^16
	function automatic logic [7:0] mix(input logic [7:0] d, input logic [7:0] s,
			input logic [7:0] a);
		logic [15:0] p0;
		logic [15:0] p1;
		logic [15:0] sum;
		p0  = {8'd0, d} * {8'd0, BYTE_MAX - a};
		p1  = {8'd0, s} * {8'd0, a};
		sum = p0 + p1;
		return sum[15:8];
	endfunction

endpackage
`default_nettype wire

### hdl/clipped_alpha_blend_compositor_core.sv
// a pushed pixel is written into the queue, then blended and registered in the output slot once that slot is free
// throughput: one pixel per clock while the queue has room and results are popped, set by the front and blend stages
// a four-entry queue between front and blend lets either side stall on its own
// reset (arst_n low, asynchronous): queue and output empty, counters at zero,
// registers at global_alpha 256, offsets 0, sizes 1, byte order bgra
`default_nettype none
module clipped_alpha_blend_compositor_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [cab_pkg::PIX_W-1:0]          source_pixel,
	input  logic [cab_pkg::PIX_W-1:0]          dest_pixel,
	output logic                               empty,
	input  logic                               pop,
	output logic [cab_pkg::PIX_W-1:0]          blended_pixel,
	output logic signed [cab_pkg::COORD_W-1:0] dest_column,
	output logic signed [cab_pkg::COORD_W-1:0] dest_row,
	output logic                               write_enable,
	output logic                               frame_end,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cab_pkg::IDX_W-1:0]          cfg_index,
	input  logic [cab_pkg::SIZE_W-1:0]         cfg_data
);

	cab_pkg::cfg_t   cfg;
	cab_pkg::entry_t q_wr_data;
	cab_pkg::entry_t q_rd_data;
	logic            q_wr;
	logic            q_rd;
	logic            q_full;
	logic            q_empty;

	cab_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cab_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.source_pixel (source_pixel),
		.dest_pixel   (dest_pixel),
		.cfg          (cfg),
		.q_full       (q_full),
		.q_wr         (q_wr),
		.q_wr_data    (q_wr_data)
	);

	cab_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (q_wr_data),
		.q_full  (q_full),
		.rd      (q_rd),
		.rd_data (q_rd_data),
		.q_empty (q_empty)
	);

	cab_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_rd_data     (q_rd_data),
		.q_rd          (q_rd),
		.empty         (empty),
		.pop           (pop),
		.blended_pixel (blended_pixel),
		.dest_column   (dest_column),
		.dest_row      (dest_row),
		.write_enable  (write_enable),
		.frame_end     (frame_end)
	);

endmodule
`default_nettype wire

### hdl/cab_regs.sv
`default_nettype none
module cab_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cab_pkg::IDX_W-1:0]      cfg_index,
	input  logic [cab_pkg::SIZE_W-1:0]     cfg_data,
	output cab_pkg::cfg_t                  cfg
);

	logic [cab_pkg::GA_W-1:0]   global_alpha_q;
	logic [cab_pkg::SIZE_W-1:0] x_offset_q;
	logic [cab_pkg::SIZE_W-1:0] y_offset_q;
	logic [cab_pkg::SIZE_W-1:0] source_width_q;
	logic [cab_pkg::SIZE_W-1:0] source_height_q;
	logic [cab_pkg::SIZE_W-1:0] dst_w_q;
	logic [cab_pkg::SIZE_W-1:0] dst_h_q;
	logic                       byte_order_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_alpha_q  <= cab_pkg::GA_FULL;
			x_offset_q      <= '0;
			y_offset_q      <= '0;
			source_width_q  <= cab_pkg::SIZE_W'(1);
			source_height_q <= cab_pkg::SIZE_W'(1);
			dst_w_q         <= cab_pkg::SIZE_W'(1);
			dst_h_q         <= cab_pkg::SIZE_W'(1);
			byte_order_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				cab_pkg::REG_GLOBAL_ALPHA:  global_alpha_q  <= cfg_data[cab_pkg::GA_W-1:0];
				cab_pkg::REG_X_OFFSET:      x_offset_q      <= cfg_data;
				cab_pkg::REG_Y_OFFSET:      y_offset_q      <= cfg_data;
				cab_pkg::REG_SOURCE_WIDTH:  source_width_q  <= cfg_data;
				cab_pkg::REG_SOURCE_HEIGHT: source_height_q <= cfg_data;
				cab_pkg::REG_DEST_WIDTH:    dst_w_q         <= cfg_data;
				cab_pkg::REG_DEST_HEIGHT:   dst_h_q         <= cfg_data;
				cab_pkg::REG_BYTE_ORDER:    byte_order_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.global_alpha  = (global_alpha_q > cab_pkg::GA_FULL) ? cab_pkg::GA_FULL
			: global_alpha_q;
		cfg.x_offset      = x_offset_q;
		cfg.y_offset      = y_offset_q;
		cfg.source_width  = cab_pkg::sat_size(source_width_q);
		cfg.source_height = cab_pkg::sat_size(source_height_q);
		cfg.dst_w         = cab_pkg::sat_size(dst_w_q);
		cfg.dst_h         = cab_pkg::sat_size(dst_h_q);
		cfg.byte_order    = byte_order_q;
	end

endmodule
`default_nettype wire

### hdl/cab_front.sv
`default_nettype none
module cab_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [cab_pkg::PIX_W-1:0]  source_pixel,
	input  logic [cab_pkg::PIX_W-1:0]  dest_pixel,
	input  cab_pkg::cfg_t              cfg,
	input  logic                       q_full,
	output logic                       q_wr,
	output cab_pkg::entry_t            q_wr_data
);

	logic [cab_pkg::CNT_W-1:0]          col_q;
	logic [cab_pkg::CNT_W-1:0]          row_q;
	logic [7:0]                         pix_alpha;
	logic [cab_pkg::GA_W+7:0]           alpha_prod;
	logic signed [cab_pkg::COORD_W-1:0] col;
	logic signed [cab_pkg::COORD_W-1:0] row;
	logic [cab_pkg::SIZE_W-1:0]         col_next;
	logic [cab_pkg::SIZE_W-1:0]         row_next;
	logic                               last_col;
	logic                               last_row;
	logic                               col_in;
	logic                               row_in;

	assign full = q_full;
	assign q_wr = push && !q_full;

	always_comb begin
		pix_alpha  = cfg.byte_order ? source_pixel[31:24] : source_pixel[7:0];
		alpha_prod = {{(cab_pkg::GA_W){1'b0}}, pix_alpha}
			* {8'd0, cfg.global_alpha};
		col = $signed({cfg.x_offset[cab_pkg::SIZE_W-1], cfg.x_offset})
			+ $signed({2'b00, col_q});
		row = $signed({cfg.y_offset[cab_pkg::SIZE_W-1], cfg.y_offset})
			+ $signed({2'b00, row_q});
		// a non-negative coordinate fits the low bits
		col_in   = !col[cab_pkg::COORD_W-1]
			&& (col[cab_pkg::SIZE_W-1:0] < cfg.dst_w);
		row_in   = !row[cab_pkg::COORD_W-1]
			&& (row[cab_pkg::SIZE_W-1:0] < cfg.dst_h);
		col_next = {1'b0, col_q} + cab_pkg::SIZE_W'(1);
		row_next = {1'b0, row_q} + cab_pkg::SIZE_W'(1);
		last_col = col_next >= cfg.source_width;
		last_row = row_next >= cfg.source_height;

		q_wr_data.src   = source_pixel;
		q_wr_data.dst   = dest_pixel;
		q_wr_data.alpha = alpha_prod[15:8];
		q_wr_data.bgra  = cfg.byte_order;
		q_wr_data.col   = col;
		q_wr_data.row   = row;
		q_wr_data.we    = col_in && row_in;
		q_wr_data.fe    = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_wr) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_next[cab_pkg::CNT_W-1:0];
			end else begin
				col_q <= col_next[cab_pkg::CNT_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

### hdl/cab_fifo.sv
`default_nettype none
module cab_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr,
	input  cab_pkg::entry_t wr_data,
	output logic            q_full,
	input  logic            rd,
	output cab_pkg::entry_t rd_data,
	output logic            q_empty
);

	cab_pkg::entry_t              mem_q [cab_pkg::FIFO_DEPTH];
	logic [cab_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [cab_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [cab_pkg::FIFO_AW:0]    count_q;

	assign q_full  = count_q == (cab_pkg::FIFO_AW+1)'(cab_pkg::FIFO_DEPTH);
	assign q_empty = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= wr_ptr_q + cab_pkg::FIFO_AW'(1);
			if (rd)
				rd_ptr_q <= rd_ptr_q + cab_pkg::FIFO_AW'(1);
			case ({wr, rd})
				2'b10:   count_q <= count_q + (cab_pkg::FIFO_AW+1)'(1);
				2'b01:   count_q <= count_q - (cab_pkg::FIFO_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### hdl/cab_back.sv
`default_nettype none
module cab_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_empty,
	input  cab_pkg::entry_t                    q_rd_data,
	output logic                               q_rd,
	output logic                               empty,
	input  logic                               pop,
	output logic [cab_pkg::PIX_W-1:0]          blended_pixel,
	output logic signed [cab_pkg::COORD_W-1:0] dest_column,
	output logic signed [cab_pkg::COORD_W-1:0] dest_row,
	output logic                               write_enable,
	output logic                               frame_end
);

	logic                               valid_q;
	logic [cab_pkg::PIX_W-1:0]          pix_q;
	logic signed [cab_pkg::COORD_W-1:0] col_q;
	logic signed [cab_pkg::COORD_W-1:0] row_q;
	logic                               we_q;
	logic                               fe_q;
	logic [cab_pkg::PIX_W-1:0]          blend;

	// output slot frees up when empty or when its beat leaves this cycle
	assign q_rd = !q_empty && (!valid_q || pop);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			if ((q_rd_data.bgra && k == 3) || (!q_rd_data.bgra && k == 0))
				blend[8*k +: 8] = cab_pkg::BYTE_MAX;
			else
				blend[8*k +: 8] = cab_pkg::mix(q_rd_data.dst[8*k +: 8],
					q_rd_data.src[8*k +: 8], q_rd_data.alpha);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			pix_q <= blend;
			col_q <= q_rd_data.col;
			row_q <= q_rd_data.row;
			we_q  <= q_rd_data.we;
			fe_q  <= q_rd_data.fe;
		end
	end

	assign empty         = !valid_q;
	assign blended_pixel = pix_q;
	assign dest_column   = col_q;
	assign dest_row      = row_q;
	assign write_enable  = we_q;
	assign frame_end     = fe_q;

endmodule
`default_nettype wire

### hdl/cab_checker.sv
`default_nettype none
`include "clipped_alpha_blend_compositor_core_assert.svh"
module cab_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               full,
	input  logic                               empty,
	input  logic                               pop,
	input  logic [cab_pkg::PIX_W-1:0]          blended_pixel,
	input  logic signed [cab_pkg::COORD_W-1:0] dest_column,
	input  logic signed [cab_pkg::COORD_W-1:0] dest_row,
	input  logic                               write_enable,
	input  logic                               frame_end
);

	// reset leaves both sides of the queue open and nothing to deliver
	`CAB_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (empty && !full), "not idle in reset")

	// every delivered beat carries an opaque alpha byte at one end
	`CAB_ASSERT(a_alpha_opaque, !empty |-> (blended_pixel[31:24] == cab_pkg::BYTE_MAX || blended_pixel[7:0] == cab_pkg::BYTE_MAX), "alpha byte not opaque")

	// a write is only flagged at non-negative coordinates
	`CAB_ASSERT(a_we_nonneg, (!empty && write_enable) |-> (!dest_column[cab_pkg::COORD_W-1] && !dest_row[cab_pkg::COORD_W-1]), "write outside frame")

	// a beat not taken stays put
	`CAB_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(blended_pixel) && $stable(dest_column) && $stable(frame_end)), "result changed while stalled")

endmodule

bind clipped_alpha_blend_compositor_core cab_checker u_cab_checker (.*);
`default_nettype wire

### sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cab_pkg::*;

	localparam int NUM_REGS   = 8;
	localparam int QUIET_MAX  = 2000;
	localparam int HOLD_BEATS = 64;

	typedef struct {
		logic [PIX_W-1:0] src;
		logic [PIX_W-1:0] dst;
	} pixel_pair_t;

	typedef struct {
		logic [PIX_W-1:0]          pixel;
		logic signed [COORD_W-1:0] col;
		logic signed [COORD_W-1:0] row;
		logic                      we;
		logic                      fe;
	} blend_result_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b1;
	logic                      push         = 1'b0;
	logic                      full;
	logic [PIX_W-1:0]          source_pixel = '0;
	logic [PIX_W-1:0]          dest_pixel   = '0;
	logic                      empty;
	logic                      pop          = 1'b0;
	logic [PIX_W-1:0]          blended_pixel;
	logic signed [COORD_W-1:0] dest_column;
	logic signed [COORD_W-1:0] dest_row;
	logic                      write_enable;
	logic                      frame_end;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	reg_idx_t                  cfg_index    = REG_GLOBAL_ALPHA;
	logic [SIZE_W-1:0]         cfg_data     = '0;

	// shadow copy of the block's registers and raster position
	logic [GA_W-1:0]          glob_alpha = GA_W'(256);
	logic signed [SIZE_W-1:0] x_off      = '0;
	logic signed [SIZE_W-1:0] y_off      = '0;
	logic [SIZE_W-1:0]        src_w      = SIZE_W'(1);
	logic [SIZE_W-1:0]        src_h      = SIZE_W'(1);
	logic [SIZE_W-1:0]        dst_w      = SIZE_W'(1);
	logic [SIZE_W-1:0]        dst_h      = SIZE_W'(1);
	logic                     bgra       = 1'b1;
	int                       col_pos    = 0;
	int                       row_pos    = 0;

	pixel_pair_t   pixel_pairs[$];
	blend_result_t expected_blends[$];

	bit push_took;
	bit pop_took;
	bit hold_off_request = 1'b0;
	int hold_left        = 0;
	int send_idle        = 0;
	int recv_idle        = 0;
	int fail_count       = 0;
	int quiet_cycles     = 0;

	clipped_alpha_blend_compositor_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.source_pixel  (source_pixel),
		.dest_pixel    (dest_pixel),
		.empty         (empty),
		.pop           (pop),
		.blended_pixel (blended_pixel),
		.dest_column   (dest_column),
		.dest_row      (dest_row),
		.write_enable  (write_enable),
		.frame_end     (frame_end),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial forever #5 clk = ~clk;

	function automatic int clamp_size(input logic [SIZE_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_FRAME_SIZE)
			return MAX_FRAME_SIZE;
		return int'(v);
	endfunction

	function automatic int blend_channel(input int d, input int s, input int a);
		return (d * (255 - a) + s * a) >> 8;
	endfunction

	function automatic void apply_register(input reg_idx_t idx, input logic [SIZE_W-1:0] v);
		case (idx)
		REG_GLOBAL_ALPHA:  glob_alpha = v[GA_W-1:0];
		REG_X_OFFSET:      x_off = v;
		REG_Y_OFFSET:      y_off = v;
		REG_SOURCE_WIDTH:  src_w = v;
		REG_SOURCE_HEIGHT: src_h = v;
		REG_DEST_WIDTH:    dst_w = v;
		REG_DEST_HEIGHT:   dst_h = v;
		REG_BYTE_ORDER:    bgra = v[0];
		default: ;
		endcase
	endfunction

	function automatic void predict_blend(input logic [PIX_W-1:0] src, input logic [PIX_W-1:0] dst);
		blend_result_t r;
		int sw, sh, dw, dh, ga, apos, alpha, c, rw, k;
		bit last_col, last_row;
		sw = clamp_size(src_w);
		sh = clamp_size(src_h);
		dw = clamp_size(dst_w);
		dh = clamp_size(dst_h);
		ga = (glob_alpha > 256) ? 256 : int'(glob_alpha);
		apos = bgra ? 24 : 0;
		alpha = (int'(src[apos +: 8]) * ga) >> 8;
		for (k = 0; k < 4; k++) begin
			if (8 * k == apos)
				r.pixel[8*k +: 8] = BYTE_MAX;
			else
				r.pixel[8*k +: 8] = 8'(blend_channel(int'(dst[8*k +: 8]),
					int'(src[8*k +: 8]), alpha));
		end
		c = int'(x_off) + col_pos;
		rw = int'(y_off) + row_pos;
		r.col = c[COORD_W-1:0];
		r.row = rw[COORD_W-1:0];
		r.we = (c >= 0) && (c < dw) && (rw >= 0) && (rw < dh);
		// a counter left past a shrunk size counts as the last column or row
		last_col = col_pos + 1 >= sw;
		last_row = row_pos + 1 >= sh;
		r.fe = last_col && last_row;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		expected_blends.push_back(r);
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic void check_result();
		blend_result_t want;
		if (expected_blends.size() == 0) begin
			note_failure($sformatf("result beat with nothing pending: pixel %h col %0d row %0d",
				blended_pixel, dest_column, dest_row));
			return;
		end
		want = expected_blends.pop_front();
		if (blended_pixel !== want.pixel)
			note_failure($sformatf("blended_pixel expected %h got %h", want.pixel, blended_pixel));
		if (dest_column !== want.col)
			note_failure($sformatf("dest_column expected %0d got %0d", want.col, dest_column));
		if (dest_row !== want.row)
			note_failure($sformatf("dest_row expected %0d got %0d", want.row, dest_row));
		if (write_enable !== want.we)
			note_failure($sformatf("write_enable expected %b got %b", want.we, write_enable));
		if (frame_end !== want.fe)
			note_failure($sformatf("frame_end expected %b got %b", want.fe, frame_end));
	endfunction

	// pixel beat accepted: predict its result
	always @(posedge clk) begin
		push_took = arst_n && push && !full;
		if (push_took) begin
			predict_blend(source_pixel, dest_pixel);
			void'(pixel_pairs.pop_front());
		end
	end

	always @(negedge clk) begin
		if (!push || push_took) begin
			if (pixel_pairs.size() != 0 && $urandom_range(99) >= send_idle) begin
				push         <= 1'b1;
				source_pixel <= pixel_pairs[0].src;
				dest_pixel   <= pixel_pairs[0].dst;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		pop_took = arst_n && pop && !empty;
		if (pop_took)
			check_result();
	end

	always @(negedge clk) begin
		if (hold_off_request) begin
			hold_left = HOLD_BEATS;
			hold_off_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("timeout: no beat for %0d cycles", QUIET_MAX);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic load_registers(input logic [SIZE_W-1:0] vals [NUM_REGS]);
		int i;
		for (i = 0; i < NUM_REGS; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			apply_register(reg_idx_t'(i), vals[i]);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (pixel_pairs.size() != 0 || expected_blends.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic run_items(input int n, input int s_idle, input int r_idle, input bit hold);
		logic [PIX_W-1:0] s, d;
		int i, pick;
		@(posedge clk);
		send_idle = s_idle;
		recv_idle = r_idle;
		hold_off_request = hold;
		for (i = 0; i < n; i++) begin
			s = $urandom;
			d = $urandom;
			pick = $urandom_range(7);
			if (pick == 0) begin
				s[31:24] = 8'h00;
				s[7:0]   = 8'h00;
			end else if (pick == 1) begin
				s[31:24] = 8'hff;
				s[7:0]   = 8'hff;
			end
			pixel_pairs.push_back('{s, d});
		end
		wait_drained();
	endtask

	task automatic random_setup();
		logic [SIZE_W-1:0] vals [NUM_REGS];
		int pick, i;
		pick = $urandom_range(9);
		vals[REG_GLOBAL_ALPHA] = SIZE_W'((pick == 0) ? 0 : (pick == 1) ? 256 :
			(pick == 2) ? $urandom_range(8191, 257) : $urandom_range(256));
		for (i = REG_X_OFFSET; i <= REG_Y_OFFSET; i++)
			vals[i] = ($urandom_range(7) == 0) ? SIZE_W'($urandom_range(8191)) :
				SIZE_W'($urandom_range(16) - 6);
		for (i = REG_SOURCE_WIDTH; i <= REG_DEST_HEIGHT; i++) begin
			pick = $urandom_range(19);
			vals[i] = SIZE_W'((pick == 0) ? 0 : (pick == 1) ? 8191 :
				(i <= REG_SOURCE_HEIGHT) ? $urandom_range(6, 1) : $urandom_range(12, 1));
		end
		vals[REG_BYTE_ORDER] = SIZE_W'(($urandom_range(7) == 0) ? $urandom_range(8191)
			: $urandom_range(1));
		load_registers(vals);
	endtask

	initial begin
		int p, n, s_idle, r_idle;
		// falling reset edge once every process is waiting
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: 1x1 frames in bgra, full opacity
		@(posedge clk);
		pixel_pairs.push_back('{32'h0000_0000, 32'h0000_0000});
		pixel_pairs.push_back('{32'hffff_ffff, 32'hffff_ffff});
		pixel_pairs.push_back('{32'hff80_40c0, 32'h0000_ffff});
		pixel_pairs.push_back('{32'h00ff_ffff, 32'hff00_0000});
		wait_drained();

		// opacity over range, zero source width, oversized dest width, argb, last row clipped
		load_registers('{300, 0, 0, 0, 3, 8191, 2, 0});
		@(posedge clk);
		pixel_pairs.push_back('{32'hffff_ffff, 32'h0000_0000});
		pixel_pairs.push_back('{32'h1234_5600, 32'hfedc_ba98});
		pixel_pairs.push_back('{32'h807f_01ff, 32'h01fe_80ff});
		wait_drained();

		// offset extremes, zero opacity, largest frames, all outside
		load_registers('{0, 13'h1000, 4095, 8191, 4096, 4096, 1, 1});
		@(posedge clk);
		repeat (5) pixel_pairs.push_back('{$urandom, $urandom});
		wait_drained();

		// shrink the source below the running column count, then wrap whole frames
		load_registers('{8191, 4095, 13'h1000, 2, 2, 1, 1, 13'h1ffe});
		@(posedge clk);
		pixel_pairs.push_back('{32'hffff_ff7f, 32'h0000_0000});
		repeat (5) pixel_pairs.push_back('{$urandom, $urandom});
		wait_drained();

		for (p = 0; p < 30; p++) begin
			s_idle = (p < 10) ? 30 : (p < 20) ? 80 : 0;
			r_idle = (p < 10) ? 80 : (p < 20) ? 30 : 0;
			n = $urandom_range(66, 30);
			random_setup();
			if (p == 7 || p == 22) begin
				// sender pauses mid-frame until every beat is back
				run_items(n / 2, s_idle, r_idle, 1'b0);
				run_items(n - n / 2, s_idle, r_idle, 1'b0);
			end else begin
				run_items(n, s_idle, r_idle, p == 3 || p == 14 || p == 25);
			end
		end

		repeat (10) @(negedge clk);
		if (fail_count == 0 && expected_blends.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
